// ----- rtl/core/sqs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sqs_pkg: shared types and constants
// Request codes, controller states, command and status bundles and the
// stream field layout for the shift queue with search.
// ----------------------------------------------------------------------------
package sqs_pkg;

  localparam int KEY_W       = 32;
  localparam int REQ_W       = 2;
  localparam int POS_W       = 4;
  localparam int FILL_W      = 5;
  localparam int IN_TDATA_W  = 40;  // req_type + key, padded to bytes
  localparam int OUT_TDATA_W = 16;  // ok + position + fill_count, padded

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_SEARCH = 2'd2
  } sqs_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } sqs_state_t;

  typedef struct packed {
    logic exec;   // apply the request just transferred
    logic scan;   // examine one match bit
    logic emit;   // load the output register
  } sqs_cmd_t;

  typedef struct packed {
    logic is_search;  // request on the input port is a search
    logic scan_done;  // match found at the scan head, or no match left
    logic out_free;   // output register can take a result this cycle
  } sqs_status_t;

endpackage : sqs_pkg
`default_nettype wire

// ----- rtl/core/sqs_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sqs_ctrl: request sequencer
// Accepts one request at a time, steps the search scan and hands the result
// to the output register.
// ----------------------------------------------------------------------------
module sqs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire sqs_pkg::sqs_status_t status,
  output sqs_pkg::sqs_cmd_t      cmd
);
  import sqs_pkg::*;

  sqs_state_t state_r;
  sqs_state_t state_nxt;
  logic       accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    accept    = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        accept    = in_tvalid;
        cmd.exec  = accept;
        if (accept) begin
          state_nxt = status.is_search ? ST_SCAN : ST_EMIT;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit = status.out_free;
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule : sqs_ctrl
`default_nettype wire

// ----- rtl/core/sqs_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sqs_datapath: shift-register queue, match vector and result register
// Cells hold the keys from the head; a remove shifts every cell forward.
// A search latches one compare per cell, then walks the match vector.
// ----------------------------------------------------------------------------
module sqs_datapath #(
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic [sqs_pkg::IN_TDATA_W-1:0]       in_tdata,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [sqs_pkg::OUT_TDATA_W-1:0]           out_tdata,
  input  wire sqs_pkg::sqs_cmd_t                    cmd,
  output sqs_pkg::sqs_status_t                      status
);
  import sqs_pkg::*;

  localparam int IdxW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  logic [KEY_W-1:0] cell_r [DEPTH];
  logic [CntW-1:0]  count_r;
  logic [CntW-1:0]  count_nxt;
  logic [DEPTH-1:0] match_r;
  logic [DEPTH-1:0] match_nxt;
  logic [IdxW-1:0]  scan_pos_r;
  logic             ok_r;
  logic [IdxW-1:0]  pos_r;

  logic             out_valid_r;
  logic             out_ok_r;
  logic [POS_W-1:0] out_pos_r;
  logic [FILL_W-1:0] out_fill_r;

  sqs_req_t         req;
  logic [KEY_W-1:0] key;
  logic             full;
  logic             empty;
  logic             do_insert;
  logic             do_remove;
  logic [31:0]      pos_ext;
  logic [31:0]      cnt_ext;

  assign req   = sqs_req_t'(in_tdata[REQ_W-1:0]);
  assign key   = in_tdata[REQ_W +: KEY_W];
  assign full  = (count_r == CntW'(DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    do_insert = 1'b0;
    do_remove = 1'b0;
    case (req)
      REQ_INSERT: do_insert = cmd.exec && !full;
      REQ_REMOVE: do_remove = cmd.exec && !empty;
      default:    ;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (do_insert) begin
      count_nxt = count_r + CntW'(1);
    end else if (do_remove) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  // one compare per valid cell
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_nxt[i] = (CntW'(i) < count_r) && (cell_r[i] == key);
    end
  end

  // cells: load at the tail on insert, shift toward the head on remove
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (do_insert && (count_r == CntW'(i))) begin
        cell_r[i] <= key;
      end else if (do_remove && (i < DEPTH - 1)) begin
        cell_r[i] <= cell_r[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // request result and search walk
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      match_r    <= match_nxt;
      scan_pos_r <= '0;
      pos_r      <= '0;
      ok_r       <= do_insert || do_remove;
    end else if (cmd.scan) begin
      if (match_r[0]) begin
        ok_r  <= 1'b1;
        pos_r <= scan_pos_r;
      end else begin
        match_r    <= match_r >> 1;
        scan_pos_r <= scan_pos_r + IdxW'(1);
      end
    end
  end

  assign pos_ext = 32'(pos_r);
  assign cnt_ext = 32'(count_r);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_ok_r   <= ok_r;
      out_pos_r  <= pos_ext[POS_W-1:0];
      out_fill_r <= cnt_ext[FILL_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - 1 - POS_W - FILL_W){1'b0}},
                       out_fill_r, out_pos_r, out_ok_r};

  assign status.is_search = (req == REQ_SEARCH);
  assign status.scan_done = match_r[0] || (match_r == '0);
  assign status.out_free  = !out_valid_r || out_tready;

endmodule : sqs_datapath
`default_nettype wire

// ----- rtl/core/shift_queue_with_search_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// shift_queue_with_search_core: FIFO of signed keys with associative search
// Sequence: an insert, remove or unused code goes from idle straight to emit,
//   where the result loads the output register; a search passes the scan state
//   first, a one-bit-a-cycle walk of the match vector that stops at a match.
// A new request is taken only in idle, after the output register has taken the
//   last result; that load waits while out_tready holds the output register.
// Reset (rst_n low, synchronous): the queue empties and the output register
//   drops its result; the key cells keep their contents.
// ----------------------------------------------------------------------------
module shift_queue_with_search_core #(
  parameter int DEPTH = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // request channel
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [sqs_pkg::IN_TDATA_W-1:0]  in_tdata,   // req_type[1:0], key[33:2]
  // result channel
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [sqs_pkg::OUT_TDATA_W-1:0]      out_tdata   // ok[0], position[4:1],
                                                           // fill_count[9:5]
);
  import sqs_pkg::*;

  sqs_cmd_t    cmd;
  sqs_status_t status;

  // Controller: take a request only in idle, step the search walk, and
  // hold the result until the output register frees up.
  sqs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: the key cells, fill count, match vector and the output
  // register that parts the result channel from the request side.
  sqs_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .status     (status)
  );

endmodule : shift_queue_with_search_core
`default_nettype wire
